/* rtl/dps_pkg.sv */
package dps_pkg;

  localparam int unsigned MAX_PROCS = 8;
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] prio;
    logic [7:0]         rem;
  } entry_t;

  typedef struct packed {
    logic   upd;
    logic   tick;
    logic   ins_en;
    entry_t ins;
  } ctrl_t;

endpackage

/* rtl/dps_cell.sv */
module dps_cell (
  input  logic            clk,
  input  dps_pkg::ctrl_t  ctrl,
  input  logic            occupied,
  input  dps_pkg::entry_t right_entry,
  input  logic            left_keep,
  input  dps_pkg::entry_t left_view,
  output dps_pkg::entry_t entry,
  output dps_pkg::entry_t view,
  output logic            keep
);

  dps_pkg::entry_t entry_next;

  // view is the slot after a tick has shifted the list towards the head
  assign view = ctrl.tick ? right_entry : entry;
  assign keep = occupied && (view.prio >= ctrl.ins.prio);

  always_comb begin
    entry_next = view;
    if (ctrl.ins_en && !keep) begin
      entry_next = left_keep ? ctrl.ins : left_view;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      entry <= entry_next;
    end
  end

endmodule

/* rtl/dynamic_priority_scheduler_top.sv */
// Dynamic priority scheduler: a ready list of up to MAX_PROCS processes kept
// sorted by priority, high first, equal priorities in arrival order.
// Items enter on start/busy: an item is taken at a clock edge with start high
// and busy low. busy is always low, so an item may be presented every cycle.
// command selects a load (insert process_id/priority_req/run_time) or a tick
// (run the head for one slice, drop its priority by one, reinsert or retire).
// Each item gives exactly one result on the next cycle, flagged by done for a
// single cycle; results cannot be held off, so the receiver must take them.
// Throughput is one item per cycle: the list is a row of cells, one per
// entry, that compare against the inserted entry in parallel and shift
// towards a neighbour in the same cycle.
// Reset (rst, synchronous) empties the list by clearing the entry count;
// cell contents are not cleared and are only read below the count.
// A load into a full list leaves it unchanged and raises load_rejected.
// ready_count reports the entry count after the item, modulo 16.
module dynamic_priority_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  process_id,
  input  logic signed [15:0] priority_req,
  input  logic [7:0]  run_time,
  output logic        done,
  output logic        ran_valid,
  output logic [7:0]  ran_id,
  output logic        finished,
  output logic [3:0]  ready_count,
  output logic        load_rejected
);

  localparam int unsigned N = dps_pkg::MAX_PROCS;
  localparam int unsigned W = dps_pkg::CNT_W;

  logic                accept;
  logic [W-1:0]        count;
  logic [W-1:0]        count_next;
  logic [W-1:0]        count_view;
  logic                full;
  logic                is_tick;
  logic                head_run;
  logic                head_done;
  dps_pkg::entry_t     head;
  dps_pkg::entry_t     load_entry;
  dps_pkg::entry_t     run_entry;
  dps_pkg::ctrl_t      ctrl;
  dps_pkg::entry_t     entries [N];
  dps_pkg::entry_t     views   [N];
  logic [N-1:0]        keeps;
  logic [W+3:0]        count_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full      = (count == W'(N));
  assign is_tick   = (command == dps_pkg::CMD_TICK);
  assign head      = entries[0];
  assign head_run  = is_tick && (count != '0);
  assign head_done = (head.rem <= 8'd1);

  always_comb begin
    load_entry.id   = process_id;
    load_entry.prio = priority_req;
    load_entry.rem  = (run_time == 8'd0) ? 8'd1 : run_time;
    run_entry.id    = head.id;
    run_entry.prio  = (head.prio == dps_pkg::PRIO_MIN) ? head.prio : head.prio - 16'sd1;
    run_entry.rem   = head.rem - 8'd1;
  end

  always_comb begin
    ctrl.upd    = accept;
    ctrl.tick   = head_run;
    ctrl.ins_en = is_tick ? (head_run && !head_done) : !full;
    ctrl.ins    = is_tick ? run_entry : load_entry;
    count_view  = head_run ? count - W'(1) : count;
    count_next  = ctrl.ins_en ? count_view + W'(1) : count_view;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    dps_pkg::entry_t right_e;
    dps_pkg::entry_t left_v;
    logic            left_k;

    if (i == N - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    if (i == 0) begin : g_first
      assign left_k = 1'b1;
      assign left_v = ctrl.ins;
    end else begin : g_rest
      assign left_k = keeps[i-1];
      assign left_v = views[i-1];
    end

    dps_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (W'(i) < count_view),
      .right_entry (right_e),
      .left_keep   (left_k),
      .left_view   (left_v),
      .entry       (entries[i]),
      .view        (views[i]),
      .keep        (keeps[i])
    );
  end

  assign count_wide  = {4'b0000, count};
  assign ready_count = count_wide[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ran_valid     <= head_run;
      ran_id        <= head_run ? head.id : 8'd0;
      finished      <= head_run && head_done;
      load_rejected <= !is_tick && full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= W'(N)) else $error("entry count beyond capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("accepted item gave no result");

  a_finished_ran: assert property (@(posedge clk) disable iff (rst)
    done && finished |-> ran_valid) else $error("finished without a run");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick && full |=> load_rejected && (count == W'(N)))
    else $error("load into full list not rejected");

  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    accept && head_run && head_done |=> count == $past(count) - W'(1))
    else $error("retired process left count unchanged");

endmodule
